[rtl/cltsr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltsr_pkg
// Shared types, constants and the microprogram of the cassette level to
// sample runs core.
// ----------------------------------------------------------------------------
package cltsr_pkg;

    // Field widths fixed by the interface
    localparam int PER_W    = 24;   // sample_period, 16 fraction bits
    localparam int CAP_W    = 20;   // silence_cap, whole cycles
    localparam int FRAC_W   = 16;   // fraction bits of the time base
    localparam int CARRY_W  = 32;   // carried rounding error, signed
    localparam int SAMPLE_W = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int GAP_LIMIT_LOG2 = 40;

    localparam int DEF_TIME_WIDTH  = 32;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam logic [PER_W-1:0] RST_SAMPLE_PERIOD = 24'd3013031;
    localparam logic [CAP_W-1:0] RST_SILENCE_CAP   = 20'd40550;
    localparam logic             RST_SOUND_ENABLE  = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] REG_SILENCE_CAP   = 2'd1;
    localparam logic [1:0] REG_SOUND_ENABLE  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_WRITE     = 2'd0,
        FUNC_MOTOR_ON  = 2'd1,
        FUNC_MOTOR_OFF = 2'd2,
        FUNC_RESET     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MODE_CLOSED = 2'd0,
        MODE_WRITE  = 2'd2,
        MODE_SOUND  = 2'd3
    } t_port_mode;

    // Datapath micro-operations
    typedef enum logic [3:0] {
        UOP_ACCEPT = 4'd0,
        UOP_DECODE = 4'd1,
        UOP_GAP    = 4'd2,
        UOP_CORR   = 4'd3,
        UOP_CAP    = 4'd4,
        UOP_NUM    = 4'd5,
        UOP_CHECK  = 4'd6,
        UOP_DIV    = 4'd7,
        UOP_NOP    = 4'd8,
        UOP_FINISH = 4'd9
    } t_uop;

    // Jump conditions: taken -> target, else next step
    typedef enum logic [2:0] {
        COND_NEXT     = 3'd0,
        COND_JUMP     = 3'd1,
        COND_NO_INPUT = 3'd2,
        COND_NO_EMIT  = 3'd3,
        COND_SHORTCUT = 3'd4,
        COND_DIV_MORE = 3'd5,
        COND_OUT_BUSY = 3'd6
    } t_cond;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_ACCEPT   = 4'd0;
    localparam t_step S_DECODE   = 4'd1;
    localparam t_step S_GAP      = 4'd2;
    localparam t_step S_CORR     = 4'd3;
    localparam t_step S_CAP      = 4'd4;
    localparam t_step S_NUM      = 4'd5;
    localparam t_step S_CHECK    = 4'd6;
    localparam t_step S_DIV      = 4'd7;
    localparam t_step S_WAIT_OUT = 4'd8;
    localparam t_step S_FINISH   = 4'd9;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic no_input;
        logic no_emit;
        logic shortcut;
        logic div_more;
        logic out_busy;
    } t_seq_flags;

    function automatic t_uword uprog(input t_step step);
        t_uword w;
        case (step)
            S_ACCEPT:   w = '{op: UOP_ACCEPT, cond: COND_NO_INPUT, target: S_ACCEPT};
            S_DECODE:   w = '{op: UOP_DECODE, cond: COND_NO_EMIT,  target: S_ACCEPT};
            S_GAP:      w = '{op: UOP_GAP,    cond: COND_NEXT,     target: S_ACCEPT};
            S_CORR:     w = '{op: UOP_CORR,   cond: COND_NEXT,     target: S_ACCEPT};
            S_CAP:      w = '{op: UOP_CAP,    cond: COND_NEXT,     target: S_ACCEPT};
            S_NUM:      w = '{op: UOP_NUM,    cond: COND_NEXT,     target: S_ACCEPT};
            S_CHECK:    w = '{op: UOP_CHECK,  cond: COND_SHORTCUT, target: S_WAIT_OUT};
            S_DIV:      w = '{op: UOP_DIV,    cond: COND_DIV_MORE, target: S_DIV};
            S_WAIT_OUT: w = '{op: UOP_NOP,    cond: COND_OUT_BUSY, target: S_WAIT_OUT};
            S_FINISH:   w = '{op: UOP_FINISH, cond: COND_JUMP,     target: S_ACCEPT};
            default:    w = '{op: UOP_NOP,    cond: COND_JUMP,     target: S_ACCEPT};
        endcase
        return w;
    endfunction

    function automatic logic [SAMPLE_W-1:0] level_sample(input logic [1:0] lvl);
        logic [SAMPLE_W-1:0] s;
        case (lvl)
            2'd0:    s = 8'd127;
            2'd1:    s = 8'd254;
            2'd2:    s = 8'd0;
            default: s = 8'd127;
        endcase
        return s;
    endfunction

endpackage

[rtl/cltsr_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cltsr_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module cltsr_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cltsr_pkg::t_seq_flags i_flags,
    output cltsr_pkg::t_uword     o_uword
);

    cltsr_pkg::t_step  r_step;
    cltsr_pkg::t_step  n_step;
    cltsr_pkg::t_uword w_uword;
    logic              w_taken;

    assign w_uword = cltsr_pkg::uprog(r_step);
    assign o_uword = w_uword;

    always_comb begin
        case (w_uword.cond)
            cltsr_pkg::COND_NEXT:     w_taken = 1'b0;
            cltsr_pkg::COND_JUMP:     w_taken = 1'b1;
            cltsr_pkg::COND_NO_INPUT: w_taken = i_flags.no_input;
            cltsr_pkg::COND_NO_EMIT:  w_taken = i_flags.no_emit;
            cltsr_pkg::COND_SHORTCUT: w_taken = i_flags.shortcut;
            cltsr_pkg::COND_DIV_MORE: w_taken = i_flags.div_more;
            cltsr_pkg::COND_OUT_BUSY: w_taken = i_flags.out_busy;
            default:                  w_taken = 1'b1;
        endcase
        n_step = w_taken ? w_uword.target : r_step + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= cltsr_pkg::S_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[rtl/cassette_level_to_sample_runs_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cassette_level_to_sample_runs_core
// Turns timestamped port events into runs of audio samples (sample byte,
// rounded run length with carried error, saturation flag).
// ----------------------------------------------------------------------------
// The block takes an item only in its accept step, so it takes no new item
// before it is through with the last. An item that yields a run goes
// through the restoring divider, one quotient bit per cycle, then waits
// while the output still holds the previous run. Runs with a rounding
// numerator at or below zero, or that clip, skip the divider.
// Reset (synchronous, active low) restores the register defaults, closes the
// port, sets the motor on and clears level, time base and carried error.
module cassette_level_to_sample_runs_core #(
    parameter int TIME_WIDTH  = cltsr_pkg::DEF_TIME_WIDTH,
    parameter int COUNT_WIDTH = cltsr_pkg::DEF_COUNT_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_func,
    input  logic [1:0]                   i_level,
    input  logic [TIME_WIDTH-1:0]        i_timestamp,
    // output channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [cltsr_pkg::SAMPLE_W-1:0] o_sample_byte,
    output logic [COUNT_WIDTH-1:0]       o_run_length,
    output logic                         o_run_saturated,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cltsr_pkg::ADDR_W-1:0] paddr,
    input  logic [cltsr_pkg::DATA_W-1:0] pwdata,
    output logic [cltsr_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int PER_W   = cltsr_pkg::PER_W;
    localparam int CAP_W   = cltsr_pkg::CAP_W;
    localparam int FRAC_W  = cltsr_pkg::FRAC_W;
    localparam int CARRY_W = cltsr_pkg::CARRY_W;
    localparam int GAP_W   = (TIME_WIDTH > cltsr_pkg::GAP_LIMIT_LOG2) ?
                             cltsr_pkg::GAP_LIMIT_LOG2 + 1 : TIME_WIDTH;
    localparam int D_W     = (GAP_W + FRAC_W + 2 > CAP_W + FRAC_W + 2) ?
                             GAP_W + FRAC_W + 2 : CAP_W + FRAC_W + 2;
    localparam int D1_W    = D_W + 1;
    localparam int NUM_W   = D_W + 2;
    localparam int REM_W   = PER_W + 1 + COUNT_WIDTH;
    localparam int CMP_W   = ((NUM_W > REM_W) ? NUM_W : REM_W) + 1;
    localparam int ERR_W   = PER_W + 2;
    localparam int CNT_W   = $clog2(COUNT_WIDTH);
    localparam int GX_W    = 65;

    localparam logic [GX_W-1:0] GAP_LIMIT = GX_W'(1) << cltsr_pkg::GAP_LIMIT_LOG2;
    localparam logic [D1_W-1:0] ERR_HI =
        {{(D1_W-CARRY_W+1){1'b0}}, {(CARRY_W-1){1'b1}}};
    localparam logic [D1_W-1:0] ERR_LO =
        {{(D1_W-CARRY_W+1){1'b1}}, {(CARRY_W-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic [PER_W-1:0] r_sample_period;
    logic [CAP_W-1:0] r_silence_cap;
    logic             r_sound_enable;
    logic [1:0]       w_reg_idx;
    logic             w_cfg_wr;
    logic [PER_W-1:0] w_period;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_period  = (r_sample_period == '0) ? PER_W'(1) : r_sample_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= cltsr_pkg::RST_SAMPLE_PERIOD;
            r_silence_cap   <= cltsr_pkg::RST_SILENCE_CAP;
            r_sound_enable  <= cltsr_pkg::RST_SOUND_ENABLE;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                cltsr_pkg::REG_SAMPLE_PERIOD: r_sample_period <= pwdata[PER_W-1:0];
                cltsr_pkg::REG_SILENCE_CAP:   r_silence_cap   <= pwdata[CAP_W-1:0];
                cltsr_pkg::REG_SOUND_ENABLE:  r_sound_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            cltsr_pkg::REG_SAMPLE_PERIOD: prdata = cltsr_pkg::DATA_W'(r_sample_period);
            cltsr_pkg::REG_SILENCE_CAP:   prdata = cltsr_pkg::DATA_W'(r_silence_cap);
            cltsr_pkg::REG_SOUND_ENABLE:  prdata = cltsr_pkg::DATA_W'(r_sound_enable);
            default:                      prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    cltsr_pkg::t_uword     w_uword;
    cltsr_pkg::t_seq_flags w_flags;

    cltsr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    // ---------------- datapath registers ----------------
    cltsr_pkg::t_func      r_func,      n_func;
    logic [1:0]            r_in_level,  n_in_level;
    logic [TIME_WIDTH-1:0] r_ts,        n_ts;

    cltsr_pkg::t_port_mode r_mode,      n_mode;
    logic                  r_motor,     n_motor;
    logic [1:0]            r_level,     n_level;
    logic [TIME_WIDTH-1:0] r_last,      n_last;
    logic [CARRY_W-1:0]    r_carry,     n_carry;

    logic [1:0]            r_new_level, n_new_level;
    logic                  r_cap_en,    n_cap_en;
    logic [GAP_W-1:0]      r_gap,       n_gap;
    logic [D_W-1:0]        r_d,         n_d;
    logic [NUM_W-1:0]      r_num,       n_num;
    logic [REM_W-1:0]      r_rem,       n_rem;
    logic [REM_W-1:0]      r_dsh,       n_dsh;
    logic [COUNT_WIDTH-1:0] r_q,        n_q;
    logic [CNT_W-1:0]      r_cnt,       n_cnt;
    logic                  r_nonpos,    n_nonpos;
    logic                  r_sat,       n_sat;

    logic                          r_out_valid, n_out_valid;
    logic [cltsr_pkg::SAMPLE_W-1:0] r_out_byte, n_out_byte;
    logic [COUNT_WIDTH-1:0]        r_out_len,   n_out_len;
    logic                          r_out_sat,   n_out_sat;

    // ---------------- event decode ----------------
    cltsr_pkg::t_port_mode w_dec_mode;
    logic                  w_dec_motor;
    logic                  w_dec_emit;
    logic                  w_dec_restart;
    logic [1:0]            w_dec_new_level;

    always_comb begin
        w_dec_mode      = r_mode;
        w_dec_motor     = r_motor;
        w_dec_emit      = 1'b0;
        w_dec_restart   = 1'b0;
        w_dec_new_level = r_level;
        case (r_func)
            cltsr_pkg::FUNC_WRITE: begin
                if (r_motor) begin
                    if (r_in_level != r_level) begin
                        w_dec_mode      = cltsr_pkg::MODE_WRITE;
                        w_dec_emit      = 1'b1;
                        w_dec_new_level = r_in_level;
                    end
                end else if (r_sound_enable) begin
                    // level 0 only opens sound mode once it is already open
                    if (!(r_mode != cltsr_pkg::MODE_SOUND && r_in_level == 2'd0)) begin
                        w_dec_mode = cltsr_pkg::MODE_SOUND;
                        if (r_in_level != r_level) begin
                            w_dec_emit      = 1'b1;
                            w_dec_new_level = r_in_level;
                        end
                    end
                end
            end
            cltsr_pkg::FUNC_MOTOR_ON: begin
                if (!r_motor) begin
                    w_dec_motor   = 1'b1;
                    w_dec_restart = 1'b1;
                end
            end
            cltsr_pkg::FUNC_MOTOR_OFF: begin
                if (r_motor) begin
                    // flush keeps the level; run is measured in write mode
                    w_dec_emit  = (r_mode == cltsr_pkg::MODE_WRITE);
                    w_dec_mode  = cltsr_pkg::MODE_CLOSED;
                    w_dec_motor = 1'b0;
                end
            end
            default: begin
                w_dec_mode = cltsr_pkg::MODE_CLOSED;
            end
        endcase
    end

    // ---------------- arithmetic ----------------
    logic [TIME_WIDTH-1:0] w_gap_raw;
    logic [GX_W-1:0]       w_gap_x;
    logic [D_W-1:0]        w_cap_x;
    logic [REM_W-1:0]      w_div_lim;
    logic [PER_W:0]        w_period2;
    logic                  w_nonpos;
    logic                  w_over;
    logic                  w_one;
    logic [D1_W-1:0]       w_one_err;
    logic [ERR_W-1:0]      w_rem_err;
    logic [CARRY_W-1:0]    w_err;
    logic [COUNT_WIDTH-1:0] w_len;

    assign w_gap_raw = r_ts - r_last;
    assign w_gap_x   = (GX_W'(w_gap_raw) > GAP_LIMIT) ? GAP_LIMIT : GX_W'(w_gap_raw);
    assign w_cap_x   = D_W'({r_silence_cap, {FRAC_W{1'b0}}});
    assign w_period2 = {w_period, 1'b0};
    assign w_div_lim = {w_period2, {COUNT_WIDTH{1'b0}}};
    assign w_nonpos  = r_num[NUM_W-1] | (r_num == '0);
    assign w_over    = (CMP_W'(r_num) >= CMP_W'(w_div_lim));

    // one sample forced: error is period - d, clipped to the carry range
    assign w_one     = r_nonpos | (r_q == '0 && !r_sat);
    assign w_one_err = D1_W'(w_period) - D1_W'($signed(r_d));
    // remainder R of (2d+p)/(2p) gives n*p - d = (p - R) / 2
    assign w_rem_err = ERR_W'(w_period) - ERR_W'(r_rem);

    always_comb begin
        if (r_sat) begin
            w_err = '0;
            w_len = '1;
        end else if (w_one) begin
            w_len = COUNT_WIDTH'(1);
            if ($signed(w_one_err) > $signed(ERR_HI)) begin
                w_err = ERR_HI[CARRY_W-1:0];
            end else if ($signed(w_one_err) < $signed(ERR_LO)) begin
                w_err = ERR_LO[CARRY_W-1:0];
            end else begin
                w_err = w_one_err[CARRY_W-1:0];
            end
        end else begin
            w_len = r_q;
            w_err = CARRY_W'($signed(w_rem_err) >>> 1);
        end
    end

    // ---------------- sequencer flags ----------------
    assign w_flags.no_input = !i_valid;
    assign w_flags.no_emit  = !w_dec_emit;
    assign w_flags.shortcut = w_nonpos | w_over;
    assign w_flags.div_more = (r_cnt != '0);
    assign w_flags.out_busy = r_out_valid & !i_ready;

    assign o_ready         = (w_uword.op == cltsr_pkg::UOP_ACCEPT);
    assign o_valid         = r_out_valid;
    assign o_sample_byte   = r_out_byte;
    assign o_run_length    = r_out_len;
    assign o_run_saturated = r_out_sat;

    // ---------------- micro-operations ----------------
    always_comb begin
        n_func      = r_func;
        n_in_level  = r_in_level;
        n_ts        = r_ts;
        n_mode      = r_mode;
        n_motor     = r_motor;
        n_level     = r_level;
        n_last      = r_last;
        n_carry     = r_carry;
        n_new_level = r_new_level;
        n_cap_en    = r_cap_en;
        n_gap       = r_gap;
        n_d         = r_d;
        n_num       = r_num;
        n_rem       = r_rem;
        n_dsh       = r_dsh;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_nonpos    = r_nonpos;
        n_sat       = r_sat;
        n_out_valid = r_out_valid & !i_ready;
        n_out_byte  = r_out_byte;
        n_out_len   = r_out_len;
        n_out_sat   = r_out_sat;

        case (w_uword.op)
            cltsr_pkg::UOP_ACCEPT: begin
                if (i_valid) begin
                    n_func     = cltsr_pkg::t_func'(i_func);
                    n_in_level = i_level;
                    n_ts       = i_timestamp;
                end
            end
            cltsr_pkg::UOP_DECODE: begin
                n_mode      = w_dec_mode;
                n_motor     = w_dec_motor;
                n_new_level = w_dec_new_level;
                n_cap_en    = (w_dec_mode == cltsr_pkg::MODE_SOUND);
                if (w_dec_restart) begin
                    n_last  = r_ts;
                    n_level = 2'd0;
                    n_carry = '0;
                end
            end
            cltsr_pkg::UOP_GAP: begin
                n_gap = w_gap_x[GAP_W-1:0];
            end
            cltsr_pkg::UOP_CORR: begin
                n_d = D_W'({r_gap, {FRAC_W{1'b0}}}) - D_W'($signed(r_carry));
            end
            cltsr_pkg::UOP_CAP: begin
                if (r_cap_en && ($signed(r_d) > $signed(w_cap_x))) begin
                    n_d = w_cap_x;
                end
            end
            cltsr_pkg::UOP_NUM: begin
                n_num = (NUM_W'($signed(r_d)) << 1) + NUM_W'(w_period);
                n_dsh = REM_W'({w_period2, {(COUNT_WIDTH-1){1'b0}}});
                n_cnt = CNT_W'(COUNT_WIDTH - 1);
                n_q   = '0;
            end
            cltsr_pkg::UOP_CHECK: begin
                n_nonpos = w_nonpos;
                n_sat    = !w_nonpos & w_over;
                n_rem    = REM_W'(r_num);
            end
            cltsr_pkg::UOP_DIV: begin
                if (r_rem >= r_dsh) begin
                    n_rem = r_rem - r_dsh;
                    n_q   = {r_q[COUNT_WIDTH-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[COUNT_WIDTH-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                n_cnt = r_cnt - 1'b1;
            end
            cltsr_pkg::UOP_FINISH: begin
                n_out_valid = 1'b1;
                n_out_byte  = cltsr_pkg::level_sample(r_level);
                n_out_len   = w_len;
                n_out_sat   = r_sat;
                n_carry     = w_err;
                n_last      = r_ts;
                n_level     = r_new_level;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= cltsr_pkg::MODE_CLOSED;
            r_motor     <= 1'b1;
            r_level     <= 2'd0;
            r_last      <= '0;
            r_carry     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_motor     <= n_motor;
            r_level     <= n_level;
            r_last      <= n_last;
            r_carry     <= n_carry;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_in_level  <= n_in_level;
        r_ts        <= n_ts;
        r_new_level <= n_new_level;
        r_cap_en    <= n_cap_en;
        r_gap       <= n_gap;
        r_d         <= n_d;
        r_num       <= n_num;
        r_rem       <= n_rem;
        r_dsh       <= n_dsh;
        r_q         <= n_q;
        r_cnt       <= n_cnt;
        r_nonpos    <= n_nonpos;
        r_sat       <= n_sat;
        r_out_byte  <= n_out_byte;
        r_out_len   <= n_out_len;
        r_out_sat   <= n_out_sat;
    end

endmodule

[verif/cassette_level_to_sample_runs_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cassette_level_to_sample_runs_core_test
// Drives timestamped port events (level writes, motor on/off, port reset) into
// the core and checks every emitted sample run (sample byte, rounded run
// length, saturation flag) against a behavioral predictor that tracks port
// mode, motor, level, time base and carried rounding error. Runs a directed
// sequence, random phases over several register settings and a carry pile-up,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module cassette_level_to_sample_runs_core_test;

    localparam int   RUN_MAX        = 65535;
    localparam int   QUIET_CYCLES   = 64;
    localparam int   WATCHDOG_LIMIT = 4000;
    localparam int   PHASE_ITEMS    = 110;
    localparam int   PILEUP_ITEMS   = 150;
    localparam int   MAX_IDLE       = 16;
    localparam longint CARRY_HI     = 64'sd2147483647;
    localparam longint CARRY_LO     = -64'sd2147483648;
    // sample byte per level, level 0 in the low byte
    localparam logic [31:0] LEVEL_BYTES = {8'd127, 8'd0, 8'd254, 8'd127};

    typedef struct {
        cltsr_pkg::t_func func;
        logic [1:0]       level;
        logic [31:0]      ts;
    } t_port_evt;

    typedef struct {
        logic [7:0]  sample;
        logic [15:0] length;
        logic        sat;
    } t_run;

    // DUT signals
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [1:0]                     i_func = '0;
    logic [1:0]                     i_level = '0;
    logic [31:0]                    i_timestamp = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [cltsr_pkg::SAMPLE_W-1:0] o_sample_byte;
    logic [15:0]                    o_run_length;
    logic                           o_run_saturated;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [cltsr_pkg::ADDR_W-1:0]   paddr = '0;
    logic [cltsr_pkg::DATA_W-1:0]   pwdata = '0;
    logic [cltsr_pkg::DATA_W-1:0]   prdata;
    logic                           pready;

    // predictor state and register copies
    logic [23:0]           m_period;
    logic [19:0]           m_cap;
    logic                  m_snd_en;
    cltsr_pkg::t_port_mode m_mode;
    logic                  m_motor;
    logic [1:0]            m_level;
    logic [31:0]           m_last;
    longint                m_carry;

    t_port_evt             port_events[$];
    t_run                  expected_runs[$];
    t_port_evt             ev;
    t_run                  want;
    logic [31:0]           cpu_time = '0;
    int                    err_count = 0;
    int                    idle_cycles = 0;
    int                    send_gap = 0;
    int                    sink_wait = 0;
    bit                    in_took = 1'b0;
    bit                    out_took = 1'b0;
    bit                    sender_idles = 1'b0;
    bit                    sink_stalls = 1'b0;

    cassette_level_to_sample_runs_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_level         (i_level),
        .i_timestamp     (i_timestamp),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample_byte   (o_sample_byte),
        .o_run_length    (o_run_length),
        .o_run_saturated (o_run_saturated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void model_reset();
        m_period = cltsr_pkg::RST_SAMPLE_PERIOD;
        m_cap    = cltsr_pkg::RST_SILENCE_CAP;
        m_snd_en = cltsr_pkg::RST_SOUND_ENABLE;
        m_mode   = cltsr_pkg::MODE_CLOSED;
        m_motor  = 1'b1;
        m_level  = 2'd0;
        m_last   = '0;
        m_carry  = 0;
    endfunction

    // Ends the run of the current level at ts and predicts its transaction.
    function automatic void close_run(input logic [1:0] nxt, input logic [31:0] ts);
        logic [31:0] gap;
        longint      per, d, capx, num, cnt, err;
        logic        clip;
        gap  = ts - m_last;
        per  = (m_period == 0) ? 64'sd1 : longint'({40'd0, m_period});
        d    = (longint'({32'd0, gap}) <<< 16) - m_carry;
        clip = 1'b0;
        if (m_mode == cltsr_pkg::MODE_SOUND) begin
            capx = longint'({44'd0, m_cap}) <<< 16;
            if (d > capx) begin
                d = capx;
                m_carry = 0;
            end
        end
        num = 2 * d + per;
        cnt = (num <= 0) ? 64'sd0 : num / (2 * per);
        if (cnt == 0)
            cnt = 1;
        if (cnt > RUN_MAX) begin
            cnt = RUN_MAX;
            clip = 1'b1;
            m_carry = 0;
        end else begin
            err = cnt * per - d;
            if (err > CARRY_HI) err = CARRY_HI;
            if (err < CARRY_LO) err = CARRY_LO;
            m_carry = err;
        end
        expected_runs.push_back('{sample: LEVEL_BYTES[m_level*8 +: 8],
                                  length: cnt[15:0], sat: clip});
        m_last  = ts;
        m_level = nxt;
    endfunction

    function automatic void apply_port_event(input t_port_evt e);
        case (e.func)
            cltsr_pkg::FUNC_WRITE: begin
                if (m_motor) begin
                    if (e.level != m_level) begin
                        m_mode = cltsr_pkg::MODE_WRITE;
                        close_run(e.level, e.ts);
                    end
                end else if (m_snd_en) begin
                    // a low write only keeps sound going, it never opens it
                    if (m_mode == cltsr_pkg::MODE_SOUND || e.level != 2'd0) begin
                        m_mode = cltsr_pkg::MODE_SOUND;
                        if (e.level != m_level)
                            close_run(e.level, e.ts);
                    end
                end
            end
            cltsr_pkg::FUNC_MOTOR_ON: begin
                if (!m_motor) begin
                    m_motor = 1'b1;
                    m_last  = e.ts;
                    m_level = 2'd0;
                    m_carry = 0;
                end
            end
            cltsr_pkg::FUNC_MOTOR_OFF: begin
                if (m_motor) begin
                    if (m_mode == cltsr_pkg::MODE_WRITE)
                        close_run(m_level, e.ts);
                    m_mode  = cltsr_pkg::MODE_CLOSED;
                    m_motor = 1'b0;
                end
            end
            default: m_mode = cltsr_pkg::MODE_CLOSED;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_event(input cltsr_pkg::t_func f, input logic [1:0] lvl,
                                        input logic [31:0] ts);
        port_events.push_back('{func: f, level: lvl, ts: ts});
    endfunction

    function automatic t_port_evt random_event();
        t_port_evt   e;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 76)      e.func = cltsr_pkg::FUNC_WRITE;
        else if (pick < 86) e.func = cltsr_pkg::FUNC_MOTOR_ON;
        else if (pick < 95) e.func = cltsr_pkg::FUNC_MOTOR_OFF;
        else                e.func = cltsr_pkg::FUNC_RESET;
        e.level = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 5)       cpu_time = $urandom();   // jump anywhere, may wrap
        else if (pick < 45) cpu_time += $urandom_range(1, 200);
        else if (pick < 75) cpu_time += $urandom_range(1, 5000);
        else if (pick < 90) cpu_time += $urandom_range(1, 100000);
        else if (pick < 95) cpu_time += $urandom_range(1, 4000000);
        e.ts = cpu_time;
        return e;
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            cltsr_pkg::REG_SAMPLE_PERIOD: m_period = val[23:0];
            cltsr_pkg::REG_SILENCE_CAP:   m_cap    = val[19:0];
            default:                      m_snd_en = val[0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Everything queued accepted, every run back, then let the core settle.
    task automatic wait_drained();
        while (port_events.size() != 0 || i_valid || expected_runs.size() != 0)
            @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [23:0] per, input logic [19:0] cap,
                             input logic snd, input int count, input bit pause_midway);
        apb_write(cltsr_pkg::REG_SAMPLE_PERIOD, {8'd0, per});
        apb_write(cltsr_pkg::REG_SILENCE_CAP, {12'd0, cap});
        apb_write(cltsr_pkg::REG_SOUND_ENABLE, {31'd0, snd});
        sender_idles = ($urandom_range(0, 3) != 0);
        sink_stalls  = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < count; k++) begin
            port_events.push_back(random_event());
            if (pause_midway && k == count / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_took) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap--;
                end else if (port_events.size() != 0) begin
                    ev = port_events.pop_front();
                    i_func      <= ev.func;
                    i_level     <= ev.level;
                    i_timestamp <= ev.ts;
                    i_valid     <= 1'b1;
                    send_gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Output sink: fresh stall drawn after every transaction
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_took)
                sink_wait = sink_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            if (sink_wait > 0) begin
                i_ready <= 1'b0;
                sink_wait--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor, checker and watchdog
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        in_took  = i_rst_n && i_valid && o_ready;
        out_took = i_rst_n && o_valid && i_ready;
        if (in_took)
            apply_port_event('{func: cltsr_pkg::t_func'(i_func), level: i_level,
                               ts: i_timestamp});
        if (out_took) begin
            if (expected_runs.size() == 0) begin
                report_mismatch($sformatf("unexpected run: byte %0d length %0d sat %0b",
                                          o_sample_byte, o_run_length, o_run_saturated));
            end else begin
                want = expected_runs.pop_front();
                if (o_sample_byte !== want.sample)
                    report_mismatch($sformatf("sample_byte expected %0d got %0d",
                                              want.sample, o_sample_byte));
                if (o_run_length !== want.length)
                    report_mismatch($sformatf("run_length expected %0d got %0d",
                                              want.length, o_run_length));
                if (o_run_saturated !== want.sat)
                    report_mismatch($sformatf("run_saturated expected %0b got %0b",
                                              want.sat, o_run_saturated));
            end
        end
        if (in_took || out_took || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles, %0d runs pending",
                     $realtime, idle_cycles, expected_runs.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        model_reset();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, motor on, port closed
        sender_idles = 1'b1;
        sink_stalls  = 1'b1;
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd0, 32'd100);       // same level, no run
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd1, 32'd1000);
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd2, 32'd1000);      // zero gap, count 1
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd3, 32'hFFFF_FFF0); // count clipped
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd0, 32'h0000_0010); // stamp wraps
        queue_event(cltsr_pkg::FUNC_MOTOR_ON,  2'd3, 32'h0000_0020); // already on
        queue_event(cltsr_pkg::FUNC_RESET,     2'd2, 32'h0000_0030);
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd1, 32'h0000_0230);
        queue_event(cltsr_pkg::FUNC_MOTOR_OFF, 2'd0, 32'h0000_0E30); // flush in write mode
        queue_event(cltsr_pkg::FUNC_MOTOR_OFF, 2'd0, 32'h0000_0F00); // already off
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd0, 32'h0000_1000); // low cannot open sound
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd2, 32'h0000_1100); // opens sound mode
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd0, 32'h0008_0000); // long silence cut
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd0, 32'h0008_0100);
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd3, 32'h0008_0900);
        queue_event(cltsr_pkg::FUNC_RESET,     2'd1, 32'h0008_0A00);
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd0, 32'h0008_0B00);
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd1, 32'h0008_0C00);
        queue_event(cltsr_pkg::FUNC_MOTOR_ON,  2'd2, 32'h7FFF_0000); // restarts time base
        queue_event(cltsr_pkg::FUNC_MOTOR_ON,  2'd0, 32'h7FFF_1000);
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd1, 32'hFFFF_FFFF);
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd2, 32'hFFFF_FFFF);
        queue_event(cltsr_pkg::FUNC_WRITE,     2'd3, 32'h0000_0000);
        wait_drained();

        // random phases over register settings, extremes included
        run_phase(24'd65536,    20'd1,       1'b0, PHASE_ITEMS, 1'b0);
        run_phase(24'd16777215, 20'd1048575, 1'b1, PHASE_ITEMS, 1'b0);
        run_phase(cltsr_pkg::RST_SAMPLE_PERIOD, cltsr_pkg::RST_SILENCE_CAP, 1'b1,
                  PHASE_ITEMS, 1'b1);
        run_phase(24'($urandom_range(65536, 16777215)), 20'($urandom_range(1, 1048575)),
                  1'($urandom_range(0, 1)), PHASE_ITEMS, 1'b0);
        run_phase(24'($urandom_range(65536, 700000)), 20'($urandom_range(1, 2000)),
                  1'b1, PHASE_ITEMS, 1'b0);
        // zero period acts as the smallest step
        run_phase(24'd0, 20'($urandom_range(1, 1048575)), 1'b1, PHASE_ITEMS, 1'b0);

        // back-to-back level changes on one stamp pile up carry
        apb_write(cltsr_pkg::REG_SAMPLE_PERIOD, 32'd16777215);
        queue_event(cltsr_pkg::FUNC_MOTOR_ON, 2'd0, cpu_time);
        for (int k = 0; k < PILEUP_ITEMS; k++)
            queue_event(cltsr_pkg::FUNC_WRITE, 2'($urandom_range(0, 3)), cpu_time);
        cpu_time += $urandom_range(1000, 90000);
        queue_event(cltsr_pkg::FUNC_WRITE, 2'($urandom_range(0, 3)), cpu_time);
        queue_event(cltsr_pkg::FUNC_MOTOR_OFF, 2'd0, cpu_time + 32'd777);
        wait_drained();

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/cltsr_pkg.sv
rtl/cltsr_seq.sv
rtl/cassette_level_to_sample_runs_core.sv
verif/cassette_level_to_sample_runs_core_test.sv
